FILE: rtl/rsi_pkg.sv
package rsi_pkg;

  localparam int NEAR_LIMIT    = 66;
  localparam int INSIDE_MARGIN = 66;
  localparam int UNIT_BITS     = 30;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } rsi_reg_t;

  // One classified ray as it passes from the front part to the back part.
  typedef struct packed {
    logic              zero_len;
    logic              in_sphere;
    logic [65:0]       ll;
    logic [2:0][32:0]  lvec;
    logic [2:0][31:0]  uvec;
    logic [2:0][31:0]  org;
  } rsi_item_t;

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] a;
    a = v[32] ? 33'(-v) : v;
    return a[31:0];
  endfunction

endpackage

FILE: rtl/rsi_sqrt.sv
module rsi_sqrt #(
  parameter int VW = 64,
  parameter int PW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [VW-1:0]     in_value,
  input  logic [PW-1:0]     in_pay,
  output logic              out_valid,
  output logic [VW/2-1:0]   out_root,
  output logic [PW-1:0]     out_pay
);

  localparam int RTW = VW / 2;
  localparam int RW  = RTW + 2;

  logic            vld  [1:RTW];
  logic [RW-1:0]   rem  [1:RTW];
  logic [RTW-1:0]  root [1:RTW];
  logic [VW-1:0]   val  [1:RTW];
  logic [PW-1:0]   pay  [1:RTW];

  // One root bit per stage: bring down two radicand bits, try 4*root+1.
  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic            s_vld;
    logic [RW-1:0]   s_rem;
    logic [RTW-1:0]  s_root;
    logic [VW-1:0]   s_val;
    logic [PW-1:0]   s_pay;
    logic [RW-1:0]   sh;
    logic [RW-1:0]   trial;

    if (k == 0) begin : g_first
      assign s_vld  = in_valid;
      assign s_rem  = '0;
      assign s_root = '0;
      assign s_val  = in_value;
      assign s_pay  = in_pay;
    end else begin : g_next
      assign s_vld  = vld[k];
      assign s_rem  = rem[k];
      assign s_root = root[k];
      assign s_val  = val[k];
      assign s_pay  = pay[k];
    end

    assign sh    = {s_rem[RW-3:0], s_val[VW-1 -: 2]};
    assign trial = {s_root, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (sh >= trial) begin
        rem[k+1]  <= sh - trial;
        root[k+1] <= {s_root[RTW-2:0], 1'b1};
      end else begin
        rem[k+1]  <= sh;
        root[k+1] <= {s_root[RTW-2:0], 1'b0};
      end
      val[k+1] <= s_val << 2;
      pay[k+1] <= s_pay;
    end
  end

  assign out_valid = vld[RTW];
  assign out_root  = root[RTW];
  assign out_pay   = pay[RTW];

endmodule

FILE: rtl/rsi_front.sv
module rsi_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic signed [31:0]      ray_origin_x,
  input  logic signed [31:0]      ray_origin_y,
  input  logic signed [31:0]      ray_origin_z,
  input  logic signed [31:0]      ray_dir_x,
  input  logic signed [31:0]      ray_dir_y,
  input  logic signed [31:0]      ray_dir_z,
  input  logic signed [31:0]      center_x,
  input  logic signed [31:0]      center_y,
  input  logic signed [31:0]      center_z,
  input  logic [30:0]             sphere_radius,
  output logic                    push,
  output rsi_pkg::rsi_item_t      item
);

  localparam int DIV_N = rsi_pkg::UNIT_BITS + 1;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][32:0] lvec;
    logic [2:0]       dsign;
    logic [2:0][31:0] mdir;
    logic [65:0]      ll;
    logic             in_sphere;
  } rsi_fpay_t;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][32:0] lvec;
    logic [2:0]       dsign;
    logic [65:0]      ll;
    logic             in_sphere;
    logic [31:0]      dlen;
  } rsi_dpay_t;

  logic signed [31:0] cv [0:2];
  logic signed [31:0] ov [0:2];
  logic signed [31:0] dv [0:2];

  assign cv[0] = center_x;
  assign cv[1] = center_y;
  assign cv[2] = center_z;
  assign ov[0] = ray_origin_x;
  assign ov[1] = ray_origin_y;
  assign ov[2] = ray_origin_z;
  assign dv[0] = ray_dir_x;
  assign dv[1] = ray_dir_y;
  assign dv[2] = ray_dir_z;

  logic [31:0] rm;
  logic [63:0] rm2;

  assign rm = 32'(sphere_radius) + 32'(rsi_pkg::INSIDE_MARGIN);

  always_ff @(posedge clk) begin
    rm2 <= rm * rm;
  end

  logic               v1, v2, v3, v4;
  logic signed [31:0] o1 [0:2];
  logic signed [31:0] d1 [0:2];
  logic [31:0]        o2 [0:2];
  logic [32:0]        l2 [0:2];
  logic [31:0]        ml2 [0:2];
  logic [31:0]        md2 [0:2];
  logic               ds2 [0:2];
  logic [31:0]        o3 [0:2];
  logic [32:0]        l3 [0:2];
  logic [31:0]        md3 [0:2];
  logic               ds3 [0:2];
  logic [63:0]        dsq3 [0:2];
  logic [63:0]        lsq3 [0:2];
  logic [63:0]        dlen2;
  logic [65:0]        llsum;
  rsi_fpay_t          fpay;

  assign llsum = 66'(lsq3[0]) + 66'(lsq3[1]) + 66'(lsq3[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [32:0] lc;

    assign lc = 33'(cv[i]) - 33'(o1[i]);

    always_ff @(posedge clk) begin
      o1[i]   <= ov[i];
      d1[i]   <= dv[i];
      o2[i]   <= o1[i];
      l2[i]   <= lc;
      ml2[i]  <= rsi_pkg::mag33(lc);
      md2[i]  <= rsi_pkg::mag33(33'(d1[i]));
      ds2[i]  <= d1[i][31];
      o3[i]   <= o2[i];
      l3[i]   <= l2[i];
      md3[i]  <= md2[i];
      ds3[i]  <= ds2[i];
      dsq3[i] <= md2[i] * md2[i];
      lsq3[i] <= ml2[i] * ml2[i];
    end
  end

  always_ff @(posedge clk) begin
    dlen2          <= dsq3[0] + dsq3[1] + dsq3[2];
    fpay.ll        <= llsum;
    fpay.in_sphere <= (llsum <= 66'(rm2));
    for (int j = 0; j < 3; j++) begin
      fpay.org[j]   <= o3[j];
      fpay.lvec[j]  <= l3[j];
      fpay.dsign[j] <= ds3[j];
      fpay.mdir[j]  <= md3[j];
    end
  end

  logic        sq_valid;
  logic [31:0] sq_root;
  rsi_fpay_t   sp;

  rsi_sqrt #(
    .VW (64),
    .PW ($bits(rsi_fpay_t))
  ) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_value  (dlen2),
    .in_pay    (fpay),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_pay   (sp)
  );

  // Three restoring dividers, one quotient bit per stage, give the unit
  // vector with UNIT_BITS fraction bits. The dividend is |d| shifted left,
  // so only its last bit is brought down and the rest are zeros.
  rsi_dpay_t          dp0;
  logic               dvld [1:DIV_N];
  logic [31:0]        drem [1:DIV_N][0:2];
  logic [DIV_N-1:0]   dquo [1:DIV_N][0:2];
  rsi_dpay_t          dpay [1:DIV_N];

  assign dp0.org       = sp.org;
  assign dp0.lvec      = sp.lvec;
  assign dp0.dsign     = sp.dsign;
  assign dp0.ll        = sp.ll;
  assign dp0.in_sphere = sp.in_sphere;
  assign dp0.dlen      = sq_root;

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    logic             s_vld;
    rsi_dpay_t        s_pay;
    logic [31:0]      s_rem [0:2];
    logic [DIV_N-1:0] s_quo [0:2];
    logic             s_bin [0:2];

    if (k == 0) begin : g_first
      assign s_vld = sq_valid;
      assign s_pay = dp0;
      for (genvar j = 0; j < 3; j++) begin : g_init
        assign s_rem[j] = {1'b0, sp.mdir[j][31:1]};
        assign s_quo[j] = '0;
        assign s_bin[j] = sp.mdir[j][0];
      end
    end else begin : g_next
      assign s_vld = dvld[k];
      assign s_pay = dpay[k];
      for (genvar j = 0; j < 3; j++) begin : g_carry
        assign s_rem[j] = drem[k][j];
        assign s_quo[j] = dquo[k][j];
        assign s_bin[j] = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k+1] <= 1'b0;
      end else begin
        dvld[k+1] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      dpay[k+1] <= s_pay;
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [32:0] sh;
      logic [32:0] dl;

      assign sh = {s_rem[j], s_bin[j]};
      assign dl = {1'b0, s_pay.dlen};

      always_ff @(posedge clk) begin
        if (sh >= dl) begin
          drem[k+1][j] <= 32'(sh - dl);
          dquo[k+1][j] <= {s_quo[j][DIV_N-2:0], 1'b1};
        end else begin
          drem[k+1][j] <= sh[31:0];
          dquo[k+1][j] <= {s_quo[j][DIV_N-2:0], 1'b0};
        end
      end
    end
  end

  rsi_dpay_t dp;

  assign dp = dpay[DIV_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= dvld[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    item.zero_len  <= (dp.dlen == 32'd0);
    item.in_sphere <= dp.in_sphere;
    item.ll        <= dp.ll;
    item.lvec      <= dp.lvec;
    item.org       <= dp.org;
    for (int j = 0; j < 3; j++) begin
      item.uvec[j] <= dp.dsign[j] ? 32'(-{1'b0, dquo[DIV_N][j]})
                                  : 32'({1'b0, dquo[DIV_N][j]});
    end
  end

endmodule

FILE: rtl/rsi_queue.sv
module rsi_queue #(
  parameter int DEPTH = rsi_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rsi_pkg::rsi_item_t push_item,
  input  logic               pop,
  output rsi_pkg::rsi_item_t pop_item,
  output logic               full,
  output logic               empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rsi_pkg::rsi_item_t mem [0:DEPTH-1];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [CW-1:0]      count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/rsi_back.sv
module rsi_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rsi_pkg::rsi_item_t  item,
  input  logic signed [31:0]  center_x,
  input  logic signed [31:0]  center_y,
  input  logic signed [31:0]  center_z,
  input  logic [30:0]         sphere_radius,
  output logic                done,
  output logic                hit,
  output logic signed [31:0]  hit_distance,
  output logic signed [31:0]  hit_pos_x,
  output logic signed [31:0]  hit_pos_y,
  output logic signed [31:0]  hit_pos_z,
  output logic signed [31:0]  normal_x,
  output logic signed [31:0]  normal_y,
  output logic signed [31:0]  normal_z
);

  localparam int UB = rsi_pkg::UNIT_BITS;

  typedef struct packed {
    logic               miss;
    logic signed [35:0] tca;
    logic [2:0][31:0]   uvec;
    logic [2:0][31:0]   org;
  } rsi_tail_t;

  logic signed [31:0] cv [0:2];

  assign cv[0] = center_x;
  assign cv[1] = center_y;
  assign cv[2] = center_z;

  logic [61:0] r2;

  always_ff @(posedge clk) begin
    r2 <= sphere_radius * sphere_radius;
  end

  logic v1, v2, v3, v4, v5, v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // Dot product of L with the unit vector, then tca and its square.
  logic signed [64:0] prod1 [0:2];
  logic [2:0][31:0]   u1, o1;
  logic [65:0]        ll1;
  logic               ins1, zero1;
  logic signed [65:0] tf;
  rsi_tail_t          t2, t3, t4, t5, t6;
  logic [65:0]        ll2, ll3, ll4;
  logic [34:0]        mtca3;
  logic [69:0]        tsq4;
  logic [65:0]        d2_5;
  logic [61:0]        rad6;

  assign tf = 66'(prod1[0]) + 66'(prod1[1]) + 66'(prod1[2]);

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      prod1[j] <= $signed(item.lvec[j]) * $signed(item.uvec[j]);
    end
    u1    <= item.uvec;
    o1    <= item.org;
    ll1   <= item.ll;
    ins1  <= item.in_sphere;
    zero1 <= item.zero_len;

    t2.miss <= zero1 || (!ins1 && tf[65]);
    t2.tca  <= 36'(tf >>> UB);
    t2.uvec <= u1;
    t2.org  <= o1;
    ll2     <= ll1;

    t3    <= t2;
    ll3   <= ll2;
    mtca3 <= t2.tca[35] ? 35'(-t2.tca) : 35'(t2.tca);

    t4   <= t3;
    ll4  <= ll3;
    tsq4 <= mtca3 * mtca3;

    t5   <= t4;
    d2_5 <= (70'(ll4) <= tsq4) ? '0 : 66'(70'(ll4) - tsq4);

    t6.miss <= t5.miss || (d2_5 > 66'(r2));
    t6.tca  <= t5.tca;
    t6.uvec <= t5.uvec;
    t6.org  <= t5.org;
    rad6    <= 62'(66'(r2) - d2_5);
  end

  logic        sq_valid;
  logic [30:0] thc;
  rsi_tail_t   ts;

  rsi_sqrt #(
    .VW (62),
    .PW ($bits(rsi_tail_t))
  ) u_thc_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_value  (rad6),
    .in_pay    (t6),
    .out_valid (sq_valid),
    .out_root  (thc),
    .out_pay   (ts)
  );

  // Root selection, then position and normal along the unit direction.
  logic signed [36:0] t0, t1, tsel;
  logic               v7, v8, v9;
  logic               miss7, miss8, miss9;
  logic [31:0]        t7, t8, t9;
  logic [2:0][31:0]   u7, o7, o8;
  logic signed [63:0] pr8 [0:2];
  logic [31:0]        p9 [0:2];

  assign t0   = 37'(ts.tca) - $signed({6'b0, thc});
  assign t1   = 37'(ts.tca) + $signed({6'b0, thc});
  assign tsel = (t0 < $signed(37'(rsi_pkg::NEAR_LIMIT))) ? t1 : t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      v7 <= sq_valid;
      v8 <= v7;
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    t7    <= rsi_pkg::sat32(40'(tsel));
    miss7 <= ts.miss;
    u7    <= ts.uvec;
    o7    <= ts.org;

    for (int j = 0; j < 3; j++) begin
      pr8[j] <= $signed(u7[j]) * $signed(t7);
    end
    t8    <= t7;
    miss8 <= miss7;
    o8    <= o7;

    for (int j = 0; j < 3; j++) begin
      p9[j] <= rsi_pkg::sat32(40'($signed(o8[j])) + 40'(pr8[j] >>> UB));
    end
    t9    <= t8;
    miss9 <= miss8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= v9;
      hit  <= v9 && !miss9;
    end
  end

  // A rejected ray reports zeros in every field.
  always_ff @(posedge clk) begin
    if (v9 && !miss9) begin
      hit_distance <= t9;
      hit_pos_x    <= p9[0];
      hit_pos_y    <= p9[1];
      hit_pos_z    <= p9[2];
      normal_x     <= rsi_pkg::sat32(40'($signed(p9[0])) - 40'(cv[0]));
      normal_y     <= rsi_pkg::sat32(40'($signed(p9[1])) - 40'(cv[1]));
      normal_z     <= rsi_pkg::sat32(40'($signed(p9[2])) - 40'(cv[2]));
    end else begin
      hit_distance <= '0;
      hit_pos_x    <= '0;
      hit_pos_y    <= '0;
      hit_pos_z    <= '0;
      normal_x     <= '0;
      normal_y     <= '0;
      normal_z     <= '0;
    end
  end

endmodule

FILE: rtl/ray_sphere_intersect.sv
// Channel      Handshake                      Word
// config       psel/penable/pwrite, pready    center_x/y/z, sphere_radius (APB)
// ray in       start, busy                    ray_origin_x/y/z, ray_dir_x/y/z
// result out   done (one-cycle strobe)        hit, hit_distance, hit_pos_*, normal_*
//
// One ray is taken every cycle while busy is low; done rises once for each accepted ray.
// The latency is set by the two bit-serial square root pipelines (32 and 31
// stages) and the 31-stage divider that forms the unit direction.
// Reset (rst, synchronous) empties every stage and the queue and restores the
// center to zero and the radius to 1.0. The result side cannot stall, so the
// queue drains every cycle and busy stays low in normal operation.
module ray_sphere_intersect #(
  parameter int QUEUE_DEPTH = rsi_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] ray_origin_x,
  input  logic signed [31:0] ray_origin_y,
  input  logic signed [31:0] ray_origin_z,
  input  logic signed [31:0] ray_dir_x,
  input  logic signed [31:0] ray_dir_y,
  input  logic signed [31:0] ray_dir_z,
  output logic               done,
  output logic               hit,
  output logic signed [31:0] hit_distance,
  output logic signed [31:0] hit_pos_x,
  output logic signed [31:0] hit_pos_y,
  output logic signed [31:0] hit_pos_z,
  output logic signed [31:0] normal_x,
  output logic signed [31:0] normal_y,
  output logic signed [31:0] normal_z
);

  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        sphere_radius;
  logic               cfg_wr;
  rsi_pkg::rsi_reg_t  reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = rsi_pkg::rsi_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      sphere_radius <= 31'd65536;
    end else if (cfg_wr) begin
      case (reg_sel)
        rsi_pkg::REG_CENTER_X: center_x      <= pwdata;
        rsi_pkg::REG_CENTER_Y: center_y      <= pwdata;
        rsi_pkg::REG_CENTER_Z: center_z      <= pwdata;
        rsi_pkg::REG_RADIUS:   sphere_radius <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rsi_pkg::REG_CENTER_X: prdata = center_x;
      rsi_pkg::REG_CENTER_Y: prdata = center_y;
      rsi_pkg::REG_CENTER_Z: prdata = center_z;
      rsi_pkg::REG_RADIUS:   prdata = {1'b0, sphere_radius};
      default:               prdata = '0;
    endcase
  end

  logic               accept;
  logic               f_push;
  rsi_pkg::rsi_item_t f_item;
  rsi_pkg::rsi_item_t q_item;
  logic               q_full;
  logic               q_empty;

  assign busy   = q_full;
  assign accept = start && !busy;

  rsi_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .ray_origin_x  (ray_origin_x),
    .ray_origin_y  (ray_origin_y),
    .ray_origin_z  (ray_origin_z),
    .ray_dir_x     (ray_dir_x),
    .ray_dir_y     (ray_dir_y),
    .ray_dir_z     (ray_dir_z),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .sphere_radius (sphere_radius),
    .push          (f_push),
    .item          (f_item)
  );

  rsi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_item (f_item),
    .pop       (!q_empty),
    .pop_item  (q_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  rsi_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (!q_empty),
    .item          (q_item),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .sphere_radius (sphere_radius),
    .done          (done),
    .hit           (hit),
    .hit_distance  (hit_distance),
    .hit_pos_x     (hit_pos_x),
    .hit_pos_y     (hit_pos_y),
    .hit_pos_z     (hit_pos_z),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z)
  );

  // A classified word must never arrive at a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(f_push && q_full))
    else $error("front pushed into a full queue");

  a_hit_needs_done: assert property (@(posedge clk) disable iff (rst)
    hit |-> done)
    else $error("hit raised without a result word");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (hit_distance == 0 && hit_pos_x == 0 && hit_pos_y == 0 &&
                        hit_pos_z == 0 && normal_x == 0 && normal_y == 0 &&
                        normal_z == 0))
    else $error("rejected ray carries nonzero fields");

endmodule
